FILE: hw/rtl/vdev_pkg.sv
// Shared definitions for the varint delta event decoder.
// Holds status codes, register indexes and field widths; no dependencies.
package vdev_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned StatusW = 3;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned GroupW  = 3;

	// Index of the last 7-bit group of a delta (bit offset 28)
	localparam logic [GroupW-1:0] LastGroup = 3'd4;

	typedef enum logic [StatusW-1:0] {
		ST_EVENT     = 3'd0,
		ST_DONE      = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_OUTSIDE   = 3'd3,
		ST_BADVARINT = 3'd4,
		ST_TRAILING  = 3'd5
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TOTAL_TICKS    = 2'd0,
		REG_EVENT_TOTAL    = 2'd1,
		REG_ENCODED_LENGTH = 2'd2,
		REG_UNUSED         = 2'd3
	} cfg_reg_t;

endpackage

FILE: hw/rtl/varint_delta_event_decoder_top.sv
// Varint delta event decoder, single module.
// Depends on vdev_pkg for status codes, register indexes and widths.
//
// Decodes a byte stream of events (base-128 tick delta, low group first, up to
// five bytes, then one volume byte) into absolute ticks. One byte is taken per
// cycle unless stalled: a byte is held in the input register, where the decode,
// the 33-bit tick add and the range compares finish, and any result lands in
// the output register. A result waiting downstream holds the byte in the input
// register, so the input stalls once that register is full. Only the last byte
// of an event or an error gives a result. The first error, or the final event,
// stops the stream; later bytes are taken and dropped. Writing any of the three
// registers restarts the stream; index 3 is ignored.
module varint_delta_event_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [vdev_pkg::ByteW-1:0]        data_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [vdev_pkg::WordW-1:0]        event_tick,
	output logic [vdev_pkg::ByteW-1:0]        event_volume,
	output logic [vdev_pkg::StatusW-1:0]      status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vdev_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [vdev_pkg::WordW-1:0]        cfg_data
);

	localparam int unsigned W = vdev_pkg::WordW;

	logic [W-1:0] total_ticks_q;
	logic [W-1:0] event_total_q;
	logic [W-1:0] encoded_length_q;

	logic                          reading_volume_q;
	logic [W-1:0]                  delta_accum_q;
	logic [vdev_pkg::GroupW-1:0]   group_q;
	logic [W-1:0]                  prior_tick_q;
	logic [W-1:0]                  pending_tick_q;
	logic [W-1:0]                  events_done_q;
	logic [W-1:0]                  bytes_seen_q;
	logic                          stopped_q;

	logic                          valid_s1;
	logic [vdev_pkg::ByteW-1:0]    byte_s1;

	logic                          out_valid_q;
	logic [W-1:0]                  tick_q;
	logic [vdev_pkg::ByteW-1:0]    volume_q;
	vdev_pkg::status_t             status_q;

	logic cfg_write;
	logic restart;
	logic s1_go;
	logic step;

	logic                          emit;
	vdev_pkg::status_t             emit_status;
	logic [W-1:0]                  emit_tick;
	logic [vdev_pkg::ByteW-1:0]    emit_volume;
	logic                          stop_next;
	logic                          reading_volume_next;
	logic [W-1:0]                  delta_accum_next;
	logic [vdev_pkg::GroupW-1:0]   group_next;
	logic [W-1:0]                  prior_tick_next;
	logic [W-1:0]                  pending_tick_next;
	logic [W-1:0]                  events_done_next;

	logic [W-1:0]                  bytes_inc;
	logic [W-1:0]                  events_inc;
	logic [W-1:0]                  part_shifted;
	logic [W-1:0]                  accum_or;
	logic [W:0]                    sum;
	logic                          part_overflow;
	logic                          at_end;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign restart   = cfg_write && (cfg_index != vdev_pkg::REG_UNUSED);

	assign s1_go    = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_go;
	assign step     = valid_s1 && s1_go;

	assign bytes_inc  = bytes_seen_q + W'(1);
	assign events_inc = events_done_q + W'(1);
	assign at_end     = bytes_inc >= encoded_length_q;

	always_comb begin
		case (group_q)
			3'd0:    part_shifted = W'(byte_s1[6:0]);
			3'd1:    part_shifted = W'(byte_s1[6:0]) << 7;
			3'd2:    part_shifted = W'(byte_s1[6:0]) << 14;
			3'd3:    part_shifted = W'(byte_s1[6:0]) << 21;
			default: part_shifted = W'(byte_s1[6:0]) << 28;
		endcase
	end

	assign part_overflow = (group_q == vdev_pkg::LastGroup) && (byte_s1[6:4] != 3'd0);
	assign accum_or      = delta_accum_q | part_shifted;
	assign sum           = {1'b0, prior_tick_q} + {1'b0, accum_or};

	always_comb begin
		emit                = 1'b0;
		emit_status         = vdev_pkg::ST_EVENT;
		emit_tick           = '0;
		emit_volume         = '0;
		stop_next           = stopped_q;
		reading_volume_next = reading_volume_q;
		delta_accum_next    = delta_accum_q;
		group_next          = group_q;
		prior_tick_next     = prior_tick_q;
		pending_tick_next   = pending_tick_q;
		events_done_next    = events_done_q;
		if (stopped_q) begin
			emit = 1'b0;
		end else if (events_done_q >= event_total_q) begin
			emit        = 1'b1;
			emit_status = vdev_pkg::ST_TRAILING;
			stop_next   = 1'b1;
		end else if (bytes_seen_q >= encoded_length_q) begin
			emit        = 1'b1;
			emit_status = vdev_pkg::ST_BADVARINT;
			stop_next   = 1'b1;
		end else if (!reading_volume_q) begin
			if (part_overflow) begin
				emit        = 1'b1;
				emit_status = vdev_pkg::ST_OVERFLOW;
				stop_next   = 1'b1;
			end else if (!byte_s1[7]) begin
				if (sum[W]) begin
					emit        = 1'b1;
					emit_status = vdev_pkg::ST_OVERFLOW;
					stop_next   = 1'b1;
				end else if (sum[W-1:0] >= total_ticks_q || at_end) begin
					emit        = 1'b1;
					emit_status = vdev_pkg::ST_OUTSIDE;
					stop_next   = 1'b1;
				end else begin
					delta_accum_next    = accum_or;
					pending_tick_next   = sum[W-1:0];
					reading_volume_next = 1'b1;
				end
			end else if (group_q == vdev_pkg::LastGroup || at_end) begin
				emit        = 1'b1;
				emit_status = vdev_pkg::ST_BADVARINT;
				stop_next   = 1'b1;
			end else begin
				delta_accum_next = accum_or;
				group_next       = group_q + vdev_pkg::GroupW'(1);
			end
		end else begin
			prior_tick_next     = pending_tick_q;
			events_done_next    = events_inc;
			reading_volume_next = 1'b0;
			delta_accum_next    = '0;
			group_next          = '0;
			emit                = 1'b1;
			emit_tick           = pending_tick_q;
			emit_volume         = byte_s1;
			if (events_inc == event_total_q) begin
				stop_next   = 1'b1;
				emit_status = (bytes_inc == encoded_length_q) ? vdev_pkg::ST_DONE
				                                              : vdev_pkg::ST_TRAILING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_ticks_q    <= '0;
			event_total_q    <= '0;
			encoded_length_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				vdev_pkg::REG_TOTAL_TICKS:    total_ticks_q    <= cfg_data;
				vdev_pkg::REG_EVENT_TOTAL:    event_total_q    <= cfg_data;
				vdev_pkg::REG_ENCODED_LENGTH: encoded_length_q <= cfg_data;
				default:                      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_volume_q <= 1'b0;
			delta_accum_q    <= '0;
			group_q          <= '0;
			prior_tick_q     <= '0;
			pending_tick_q   <= '0;
			events_done_q    <= '0;
			bytes_seen_q     <= '0;
			stopped_q        <= 1'b0;
		end else if (restart) begin
			reading_volume_q <= 1'b0;
			delta_accum_q    <= '0;
			group_q          <= '0;
			prior_tick_q     <= '0;
			pending_tick_q   <= '0;
			events_done_q    <= '0;
			bytes_seen_q     <= '0;
			stopped_q        <= 1'b0;
		end else if (step && !stopped_q) begin
			reading_volume_q <= reading_volume_next;
			delta_accum_q    <= delta_accum_next;
			group_q          <= group_next;
			prior_tick_q     <= prior_tick_next;
			pending_tick_q   <= pending_tick_next;
			events_done_q    <= events_done_next;
			bytes_seen_q     <= bytes_inc;
			stopped_q        <= stop_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			tick_q   <= emit_tick;
			volume_q <= emit_volume;
			status_q <= emit_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_tick   = tick_q;
	assign event_volume = volume_q;
	assign status       = status_q;

endmodule
